/* design/kts_pkg.sv */
// Shared types and constants for the keyframe track sampler.
`timescale 1ns / 1ps

package kts_pkg;

   localparam int MAX_KEYS = 64;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int CFG_W    = 7;
   localparam int FRAME_W  = 32;
   localparam int VAL_W    = 32;
   localparam int LANES    = 3;
   localparam int DIV_W    = $clog2(VAL_W);

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic [VAL_W-1:0]   z;
      logic [VAL_W-1:0]   y;
      logic [VAL_W-1:0]   x;
      logic [FRAME_W-1:0] frame;
   } key_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HINT,
      ST_HINT_CHK,
      ST_NEXT_CHK,
      ST_SCAN,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RES_MISS,
      RES_KEY0,
      RES_INTERP
   } res_mode_type;

   typedef struct packed {
      logic             wr_en;
      logic             cap_frame;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
      logic             load;
      logic             mul;
      logic             div_step;
      logic             res_load;
      res_mode_type     res_mode;
      logic [IDX_W-1:0] res_index;
   } cmd_type;

   typedef struct packed {
      logic ge_a;
      logic lt_b;
   } status_type;

endpackage

/* design/kts_datapath.sv */
// Key table, frame compares, interpolation lanes and result register.
`timescale 1ns / 1ps

module kts_datapath
   import kts_pkg::*;
(
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] wr_slot,
   input  key_type          wr_key,
   input  logic [FRAME_W-1:0] sample_frame,
   output status_type       status,
   output logic             res_found,
   output logic [IDX_W-1:0] res_index,
   output logic [VAL_W-1:0] res_x,
   output logic [VAL_W-1:0] res_y,
   output logic [VAL_W-1:0] res_z
);

   key_type            mem_ff [MAX_KEYS];
   key_type            rd_a_ff;
   key_type            rd_b_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [FRAME_W-1:0] dist_ff;
   logic [FRAME_W-1:0] span_ff;
   logic [VAL_W-1:0]   a_ff   [LANES];
   logic [VAL_W-1:0]   mag_ff [LANES];
   logic               neg_ff [LANES];
   logic [VAL_W-1:0]   rem_ff [LANES];
   logic [VAL_W-1:0]   lo_ff  [LANES];
   logic               found_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [VAL_W-1:0]   val_ff [LANES];

   logic [VAL_W-1:0]   a_val [LANES];
   logic [VAL_W-1:0]   b_val [LANES];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_slot] <= wr_key;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem_ff[cmd.rd_addr_a];
         rd_b_ff <= mem_ff[cmd.rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_frame) begin
         frame_ff <= sample_frame;
      end
   end

   assign status.ge_a = rd_a_ff.frame >= frame_ff;
   assign status.lt_b = rd_b_ff.frame <  frame_ff;

   assign a_val[0] = rd_a_ff.x;
   assign a_val[1] = rd_a_ff.y;
   assign a_val[2] = rd_a_ff.z;
   assign b_val[0] = rd_b_ff.x;
   assign b_val[1] = rd_b_ff.y;
   assign b_val[2] = rd_b_ff.z;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dist_ff <= rd_a_ff.frame - frame_ff;
         span_ff <= rd_a_ff.frame - rd_b_ff.frame;
      end
   end

   // One restoring divide step a cycle per lane; the quotient shifts into lo_ff.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [VAL_W:0]     diff;
      logic [VAL_W:0]     diff_neg;
      logic [2*VAL_W-1:0] prod;
      logic [VAL_W:0]     trial;
      logic               take;

      assign diff     = {a_val[l][VAL_W-1], a_val[l]} - {b_val[l][VAL_W-1], b_val[l]};
      assign diff_neg = (VAL_W+1)'(0) - diff;
      assign prod     = (2*VAL_W)'(mag_ff[l]) * (2*VAL_W)'(dist_ff);
      assign trial    = {rem_ff[l], lo_ff[l][VAL_W-1]};
      assign take     = trial >= {1'b0, span_ff};

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            a_ff[l]   <= a_val[l];
            neg_ff[l] <= diff[VAL_W];
            mag_ff[l] <= diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
         end
         if (cmd.mul) begin
            rem_ff[l] <= prod[2*VAL_W-1:VAL_W];
            lo_ff[l]  <= prod[VAL_W-1:0];
         end else if (cmd.div_step) begin
            if (take) begin
               rem_ff[l] <= VAL_W'(trial - {1'b0, span_ff});
            end else begin
               rem_ff[l] <= trial[VAL_W-1:0];
            end
            lo_ff[l] <= {lo_ff[l][VAL_W-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.res_load) begin
            unique case (cmd.res_mode)
               RES_MISS: begin
                  val_ff[l] <= '0;
               end
               RES_KEY0: begin
                  val_ff[l] <= a_val[l];
               end
               RES_INTERP: begin
                  val_ff[l] <= neg_ff[l] ? a_ff[l] + lo_ff[l] : a_ff[l] - lo_ff[l];
               end
               default: begin
                  val_ff[l] <= '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         found_ff <= cmd.res_mode != RES_MISS;
         index_ff <= (cmd.res_mode == RES_MISS) ? '0 : cmd.res_index;
      end
   end

   assign res_found = found_ff;
   assign res_index = index_ff;
   assign res_x     = val_ff[0];
   assign res_y     = val_ff[1];
   assign res_z     = val_ff[2];

endmodule

/* design/kts_ctrl.sv */
// Controller: key count register, search hint, lookup sequencing and result handshake.
`timescale 1ns / 1ps

module kts_ctrl
   import kts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_kind,
   input  logic             csr_wen,
   input  logic [CFG_W-1:0] csr_wdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  status_type       status,
   output cmd_type          cmd
);

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] key_count_ff;
   logic [IDX_W-1:0] hint_ff, hint_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [DIV_W-1:0] div_cnt_ff, div_cnt_in;
   res_mode_type     mode_ff, mode_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0] cnt;
   logic [CNT_W-1:0] hint_ext;
   logic             hint_ok;
   logic             next_ok;
   logic             accept;

   assign cnt      = (key_count_ff > CFG_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                       : CNT_W'(key_count_ff);
   assign hint_ext = {1'b0, hint_ff};
   assign hint_ok  = hint_ext < cnt;
   assign next_ok  = (hint_ext + CNT_W'(1)) < cnt;
   assign accept   = req_tvalid && req_tready;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         hint_ff      <= '0;
         idx_ff       <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         mode_ff      <= RES_MISS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         idx_ff       <= idx_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         div_cnt_ff   <= div_cnt_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            key_count_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      hint_in    = hint_ff;
      idx_in     = idx_ff;
      scan_in    = scan_ff;
      pend_in    = pend_ff;
      div_cnt_in = div_cnt_ff;
      mode_in    = mode_ff;

      cmd           = '0;
      cmd.res_mode  = mode_ff;
      cmd.res_index = idx_ff;
      cmd.wr_en     = accept && (req_kind == KIND_WRITE);
      cmd.cap_frame = accept && (req_kind == KIND_SAMPLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_SAMPLE)) begin
               state_in = ST_HINT;
            end
         end
         ST_HINT: begin
            scan_in = '0;
            pend_in = 1'b0;
            if (hint_ok && (hint_ff != '0)) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_addr_a = hint_ff;
               cmd.rd_addr_b = hint_ff - IDX_W'(1);
               state_in      = ST_HINT_CHK;
            end else if (hint_ok && next_ok) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_addr_a = hint_ff + IDX_W'(1);
               cmd.rd_addr_b = hint_ff;
               state_in      = ST_NEXT_CHK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_HINT_CHK: begin
            if (status.ge_a && status.lt_b) begin
               idx_in   = hint_ff;
               state_in = ST_FETCH;
            end else if (next_ok) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_addr_a = hint_ff + IDX_W'(1);
               cmd.rd_addr_b = hint_ff;
               state_in      = ST_NEXT_CHK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_NEXT_CHK: begin
            if (status.ge_a && status.lt_b) begin
               hint_in  = hint_ff + IDX_W'(1);
               idx_in   = hint_ff + IDX_W'(1);
               state_in = ST_FETCH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one key a cycle and test the key read on the cycle before.
            if (pend_ff && status.ge_a) begin
               hint_in  = IDX_W'(scan_ff - CNT_W'(1));
               idx_in   = IDX_W'(scan_ff - CNT_W'(1));
               state_in = ST_FETCH;
            end else if (scan_ff == cnt) begin
               mode_in  = RES_MISS;
               state_in = ST_DONE;
            end else begin
               cmd.rd_en     = 1'b1;
               cmd.rd_addr_a = scan_ff[IDX_W-1:0];
               scan_in       = scan_ff + CNT_W'(1);
               pend_in       = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = idx_ff;
            cmd.rd_addr_b = idx_ff - IDX_W'(1);
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (idx_ff == '0) begin
               mode_in  = RES_KEY0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul    = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_W'(1);
            if (div_cnt_ff == DIV_W'(VAL_W - 1)) begin
               mode_in  = RES_INTERP;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   a_res_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken transfer");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_SAMPLE)) |=> (state_ff == ST_HINT))
      else $error("sample transfer did not start a lookup");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= CNT_W'(MAX_KEYS))
      else $error("scan index beyond table");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (div_cnt_ff == '0))
      else $error("divide counter left running");

endmodule

/* design/keyframe_track_sampler.sv */
// Top level of the keyframe track sampler: controller and datapath.
`timescale 1ns / 1ps

// Holds one animation track of up to 64 keys and samples it by linear
// interpolation. A key write transfer (tuser 0) stores a key. A sample
// transfer (tuser 1) tries the stored hint key, then the key after it, then
// scans the table from key 0 one key a cycle through the two-port key memory;
// the interpolation quotient comes from a restoring divider that produces one
// bit a cycle. Only one sample is in work at a time; the result register lets
// the next transfer in while a result waits. Keys never written read back as
// anything.

module keyframe_track_sampler
   import kts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // key_slot, key_frame, value_x, value_y, value_z, sample_frame, zero pad
   input  logic [167:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // used_index, out_x, out_y, out_z, zero pad
   output logic [103:0] rsp_tdata,
   // found
   output logic         rsp_tuser,
   input  logic         csr_wen,
   input  logic [6:0]   csr_wdata
);

   cmd_type          cmd;
   status_type       status;
   key_type          wr_key;
   logic [IDX_W-1:0] res_index;
   logic [VAL_W-1:0] res_x;
   logic [VAL_W-1:0] res_y;
   logic [VAL_W-1:0] res_z;

   assign wr_key.frame = req_tdata[37:6];
   assign wr_key.x     = req_tdata[69:38];
   assign wr_key.y     = req_tdata[101:70];
   assign wr_key.z     = req_tdata[133:102];

   kts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kts_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .wr_slot      (req_tdata[5:0]),
      .wr_key       (wr_key),
      .sample_frame (req_tdata[165:134]),
      .status       (status),
      .res_found    (rsp_tuser),
      .res_index    (res_index),
      .res_x        (res_x),
      .res_y        (res_y),
      .res_z        (res_z)
   );

   assign rsp_tdata = {2'b00, res_z, res_y, res_x, res_index};

endmodule
